// File: src/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by dq_cell, double_ended_queue and dq_checker; depends on nothing.
package dq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VAL_W         = 32;
  localparam int OP_W          = 3;
  localparam int STAT_W        = 2;

  // Operation codes on in_operation
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  // Status codes on out_status
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,   // push front: every cell takes its left neighbor
    CELL_SHIFT_OUT,  // pop front: every cell takes its right neighbor
    CELL_APPEND,     // push back: first empty cell takes the pushed value
    CELL_DROP_TAIL,  // pop back: last occupied cell empties
    CELL_ROTATE      // dump step: shift left, head wraps into the tail
  } cell_op_t;

  typedef enum logic {
    S_RUN,
    S_DUMP
  } fsm_t;

  typedef struct packed {
    cell_op_t               op;
    logic [VAL_W-1:0]       push_val;
    logic [VAL_W-1:0]       head_val;
  } cell_cmd_t;

endpackage

// File: src/dq_cell.sv
// One storage cell of the queue row: a value and an occupancy bit.
// Depends on dq_pkg for the command struct and widths.
module dq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dq_pkg::cell_cmd_t          cmd,
  input  logic [dq_pkg::VAL_W-1:0]   left_val,
  input  logic                       left_occ,
  input  logic [dq_pkg::VAL_W-1:0]   right_val,
  input  logic                       right_occ,
  output logic [dq_pkg::VAL_W-1:0]   val,
  output logic                       occ,
  output logic [dq_pkg::VAL_W-1:0]   tail_val
);

  logic [dq_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                     occ_r, occ_nxt;
  logic                     is_tail;

  assign is_tail  = occ_r & ~right_occ;
  assign val      = val_r;
  assign occ      = occ_r;
  assign tail_val = is_tail ? val_r : '0;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    unique case (cmd.op)
      dq_pkg::CELL_HOLD: ;
      dq_pkg::CELL_SHIFT_IN: begin
        val_nxt = left_val;
        occ_nxt = left_occ;
      end
      dq_pkg::CELL_SHIFT_OUT: begin
        val_nxt = right_val;
        occ_nxt = right_occ;
      end
      dq_pkg::CELL_APPEND: begin
        if (~occ_r & left_occ) begin
          val_nxt = cmd.push_val;
          occ_nxt = 1'b1;
        end
      end
      dq_pkg::CELL_DROP_TAIL: begin
        if (is_tail) occ_nxt = 1'b0;
      end
      dq_pkg::CELL_ROTATE: begin
        if (is_tail) val_nxt = cmd.head_val;
        else if (occ_r) val_nxt = right_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    val_r <= val_nxt;
  end

endmodule

// File: src/double_ended_queue.sv
// Top level of the bounded double-ended queue: row of dq_cell, control FSM,
// output register. Depends on dq_pkg and dq_cell.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one operation and a value per
//   beat. Result channel (out_valid/out_stall) carries result_value, status
//   and last; last marks the final result beat of an input beat.
//   Entries live front-aligned in a row of DEPTH cells; cell 0 is the front.
//   Pushes and pops shift the row or touch a single cell of it.
//   A result appears in the output register in the cycle after accept.
//   Pushes and pops are accepted back to back, one per cycle, while the
//   receiver takes results. Dump first loads its entry count, then sends one
//   beat per cycle while the receiver takes results; the row rotates once,
//   shifting the front value out and wrapping it to the tail, so the order
//   is intact at the end. in_stall is high during a dump.
//   Unused operation codes (5 to 7) are consumed with no result.
//   When out_stall is high with a result pending, in_stall goes high and the
//   row holds until the result is taken.
//   Reset (rst_n low, synchronous) empties the queue and clears out_valid.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [dq_pkg::VAL_W-1:0]  in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [dq_pkg::VAL_W-1:0]  out_result_value,
  output logic [dq_pkg::STAT_W-1:0]        out_status,
  output logic                             out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Cell row
  logic [dq_pkg::VAL_W-1:0] cell_val  [DEPTH];
  logic                     cell_occ  [DEPTH];
  logic [dq_pkg::VAL_W-1:0] cell_tail [DEPTH];
  dq_pkg::cell_cmd_t        cmd;
  dq_pkg::cell_op_t         cell_op;
  logic [dq_pkg::VAL_W-1:0] tail_val;

  // Control
  dq_pkg::fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic                     slot_free, accept, is_full, is_empty;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [dq_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [dq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;

  assign slot_free = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != dq_pkg::S_RUN) | ~slot_free;
  assign accept    = in_valid & ~in_stall;
  assign is_full   = (cnt_r == CNT_FULL);
  assign is_empty  = (cnt_r == '0);

  assign cmd.op       = cell_op;
  assign cmd.push_val = in_value;
  assign cmd.head_val = cell_val[0];

  // Front cell's left neighbor is the incoming value (used by push front);
  // its occupancy is tied high so push back fills cell 0 of an empty row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dq_pkg::VAL_W-1:0] lv, rv;
    logic                     lo, ro;
    if (i == 0) begin : g_head
      assign lv = in_value;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_nxt
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lv),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .val       (cell_val[i]),
      .occ       (cell_occ[i]),
      .tail_val  (cell_tail[i])
    );
  end

  // At most one cell flags itself as tail (none when empty); OR the masked values together.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | cell_tail[i];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::S_RUN: begin
        if (accept && in_operation == dq_pkg::OP_DUMP && !is_empty)
          state_nxt = dq_pkg::S_DUMP;
      end
      dq_pkg::S_DUMP: begin
        if (slot_free && rem_r == CNT_ONE) state_nxt = dq_pkg::S_RUN;
      end
      default: state_nxt = dq_pkg::S_RUN;
    endcase
  end

  // Datapath and result beats
  always_comb begin
    cell_op        = dq_pkg::CELL_HOLD;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      dq_pkg::S_RUN: begin
        if (accept) begin
          out_last_nxt = 1'b1;
          unique case (in_operation)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = in_value;
              if (is_full) begin
                out_status_nxt = dq_pkg::STAT_FULL;
              end else begin
                out_status_nxt = dq_pkg::STAT_OK;
                cnt_nxt        = cnt_r + CNT_ONE;
                cell_op        = (in_operation == dq_pkg::OP_PUSH_FRONT) ?
                                 dq_pkg::CELL_SHIFT_IN : dq_pkg::CELL_APPEND;
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_value_nxt  = '0;
                out_status_nxt = dq_pkg::STAT_EMPTY;
              end else begin
                out_status_nxt = dq_pkg::STAT_OK;
                cnt_nxt        = cnt_r - CNT_ONE;
                if (in_operation == dq_pkg::OP_POP_FRONT) begin
                  out_value_nxt = cell_val[0];
                  cell_op       = dq_pkg::CELL_SHIFT_OUT;
                end else begin
                  out_value_nxt = tail_val;
                  cell_op       = dq_pkg::CELL_DROP_TAIL;
                end
              end
            end
            dq_pkg::OP_DUMP: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_value_nxt  = '0;
                out_status_nxt = dq_pkg::STAT_EMPTY;
              end else begin
                rem_nxt = cnt_r;
              end
            end
            default: ;  // unused codes: consumed, no result
          endcase
        end
      end
      dq_pkg::S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = cell_val[0];
          out_status_nxt = dq_pkg::STAT_OK;
          out_last_nxt   = (rem_r == CNT_ONE);
          rem_nxt        = rem_r - CNT_ONE;
          cell_op        = dq_pkg::CELL_ROTATE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_RUN;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_value_r);
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

// File: src/dq_checker.sv
// Port-level checks for double_ended_queue, bound to the top level.
// Depends on dq_pkg for widths and status codes.
module dq_sva (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [dq_pkg::OP_W-1:0]          in_operation,
  input logic signed [dq_pkg::VAL_W-1:0]  in_value,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [dq_pkg::VAL_W-1:0]  out_result_value,
  input logic [dq_pkg::STAT_W-1:0]        out_status,
  input logic                             out_last
);

  // A held result blocks the input side.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result beat is stalled");

  // Empty and full answers are single-beat results.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dq_pkg::STAT_OK |-> out_last)
    else $error("empty/full result without last");

  // Status code 3 is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == dq_pkg::STAT_OK || out_status == dq_pkg::STAT_EMPTY
                   || out_status == dq_pkg::STAT_FULL))
    else $error("bad status code");

  // Stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
                               && $stable(out_status) && $stable(out_last))
    else $error("stalled result beat changed");

  // Nothing comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind double_ended_queue dq_sva u_dq_sva (.*);

// File: dv/dq_checker.sv
`timescale 1ns / 100ps
// Result checker for the double-ended queue: watches both channels, keeps a
// shadow ring of its own and compares each result beat. Depends on dq_pkg.
module dq_checker
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [VAL_W-1:0] out_result_value,
  input  logic [STAT_W-1:0]       out_status,
  input  logic                    out_last,
  input  logic                    wrap_up,
  output int                      pending,
  output int                      fail_count,
  output int                      beats_checked,
  output int                      full_hits,
  output int                      empty_hits
);

  localparam int IDX_W = $clog2(DEPTH);

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } dq_result_t;

  // shadow of the queue contents
  logic signed [VAL_W-1:0] ring_cells [DEPTH];
  logic [IDX_W-1:0]        head_pos;
  logic [IDX_W:0]          fill_level;

  dq_result_t due_results[$];
  int fails, seen, fulls, empties;
  bit wrapped;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic queue_result(input logic signed [VAL_W-1:0] v,
                              input logic [STAT_W-1:0] st, input logic lst);
    dq_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    due_results.push_back(r);
  endtask

  // one accepted operation: update the shadow, queue the beats it owes
  task automatic apply_to_shadow(input logic [OP_W-1:0] op,
                                 input logic signed [VAL_W-1:0] v);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          queue_result(v, STAT_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_pos = (head_pos == 0) ? IDX_W'(DEPTH - 1) : head_pos - 1'b1;
            ring_cells[head_pos] = v;
          end else begin
            ring_cells[IDX_W'((head_pos + fill_level) % DEPTH)] = v;
          end
          fill_level++;
          queue_result(v, STAT_OK, 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          queue_result(ring_cells[head_pos], STAT_OK, 1'b1);
          head_pos = (head_pos == IDX_W'(DEPTH - 1)) ? '0 : head_pos + 1'b1;
          fill_level--;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          queue_result(ring_cells[IDX_W'((head_pos + fill_level - 1) % DEPTH)],
                       STAT_OK, 1'b1);
          fill_level--;
        end
      end
      OP_DUMP: begin
        if (fill_level == 0) begin
          queue_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < fill_level; i++)
            queue_result(ring_cells[IDX_W'((head_pos + i) % DEPTH)], STAT_OK,
                         i + 1 == fill_level);
        end
      end
      default: ;  // spare codes: swallowed, no beat
    endcase
  endtask

  task automatic check_beat();
    dq_result_t want;
    seen++;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("beat %0d arrived with nothing due (value %0d status %0d)",
                                seen, out_result_value, out_status));
      return;
    end
    want = due_results.pop_front();
    if (out_result_value !== want.value)
      report_mismatch($sformatf("beat %0d value %0d, want %0d",
                                seen, out_result_value, want.value));
    if (out_status !== want.status)
      report_mismatch($sformatf("beat %0d status %0d, want %0d", seen, out_status, want.status));
    if (out_last !== want.last)
      report_mismatch($sformatf("beat %0d last %0b, want %0b", seen, out_last, want.last));
    if (want.status == STAT_FULL) fulls++;
    if (want.status == STAT_EMPTY) empties++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      head_pos   = '0;
      fill_level = '0;
    end else begin
      // result first: it can never belong to an operation taken this edge
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) apply_to_shadow(in_operation, in_value);
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (due_results.size() != 0)
          report_mismatch($sformatf("%0d result beats never arrived", due_results.size()));
      end
    end
    pending       <= due_results.size();
    fail_count    <= fails;
    beats_checked <= seen;
    full_hits     <= fulls;
    empty_hits    <= empties;
  end

endmodule

// File: dv/double_ended_queue_tb.sv
`timescale 1ns / 100ps
// Top of the double-ended queue testbench: clock, reset, stimulus, receiver
// back-pressure and verdict. Depends on dq_pkg, double_ended_queue, dq_checker.
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DQ_DEPTH    = DEPTH_DEFAULT;
  localparam int RANDOM_OPS  = 75;
  localparam int HOLD_LEN    = 60;      // long receiver hold-off, in cycles
  localparam int TAIL_CYCLES = 20;      // settle time after the last beat
  localparam int CYCLE_LIMIT = 200000;

  // codes the block must swallow without a result
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation = '0;
  logic signed [VAL_W-1:0] in_value     = '0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic signed [VAL_W-1:0] out_result_value;
  logic [STAT_W-1:0]       out_status;
  logic                    out_last;
  logic                    wrap_up      = 1'b0;

  int chk_pending, chk_fails, chk_beats, chk_fulls, chk_empties;

  // stimulus knobs
  bit tx_gaps = 1'b0;       // sender idles at random
  bit rx_gaps = 1'b0;       // receiver stalls at random
  int hold_ask = 0;         // bumped to request one long hold-off
  int ops_issued = 0;       // operations that owe a result
  int spares_issued = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  double_ended_queue #(.DEPTH(DQ_DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  dq_checker #(.DEPTH(DQ_DEPTH)) chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last),
    .wrap_up          (wrap_up),
    .pending          (chk_pending),
    .fail_count       (chk_fails),
    .beats_checked    (chk_beats),
    .full_hits        (chk_fulls),
    .empty_hits       (chk_empties)
  );

  // Watchdog: a hung block or a lost beat ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count, chk_pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls when enabled, plus a long hold-off on request.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_stall <= rx_gaps && ($urandom_range(99) < 9);
    end
  end

  // Offer one beat and wait for it to be taken. Called right after an edge.
  // valid only drops on an idle cycle, never between back-to-back beats.
  task automatic issue_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v);
    while (tx_gaps && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (in_stall);
    if (op > OP_DUMP) spares_issued++;
    else ops_issued++;
  endtask

  // Sender pause: nothing offered until every due beat has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
  endtask

  // mostly random, with the corners mixed in
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 25)      return OP_PUSH_FRONT;
    else if (r < 50) return OP_PUSH_BACK;
    else if (r < 68) return OP_POP_FRONT;
    else if (r < 86) return OP_POP_BACK;
    else if (r < 96) return OP_DUMP;
    else if (r < 97) return OP_SPARE_A;
    else if (r < 98) return OP_SPARE_B;
    else             return OP_SPARE_C;
  endfunction

  // Push past capacity from either end, then dump whatever is held.
  task automatic fill_run();
    repeat (DQ_DEPTH + 2)
      issue_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    issue_op(OP_DUMP, $urandom);
  endtask

  // Dump, then pop from either end until well past empty.
  task automatic drain_run();
    issue_op(OP_DUMP, $urandom);
    repeat (DQ_DEPTH + 2)
      issue_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
  endtask

  task automatic mixed_run();
    repeat (12) issue_op(pick_op(), pick_value());
  endtask

  initial begin
    int random_start;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-store answers, spare codes, extreme values at both
    // ends, a dump in order, then pops down through one entry to empty.
    issue_op(OP_POP_FRONT, $urandom);
    issue_op(OP_POP_BACK, $urandom);
    issue_op(OP_DUMP, $urandom);
    issue_op(OP_SPARE_A, $urandom);
    issue_op(OP_SPARE_B, $urandom);
    issue_op(OP_SPARE_C, $urandom);
    issue_op(OP_PUSH_FRONT, VAL_MIN);
    issue_op(OP_PUSH_BACK, VAL_MAX);
    issue_op(OP_PUSH_FRONT, '0);
    issue_op(OP_PUSH_BACK, '1);
    issue_op(OP_DUMP, $urandom);
    issue_op(OP_POP_BACK, $urandom);
    issue_op(OP_POP_FRONT, $urandom);
    issue_op(OP_POP_BACK, $urandom);
    issue_op(OP_POP_FRONT, $urandom);    // last entry leaves
    issue_op(OP_POP_BACK, $urandom);     // empty again
    wait_drained();

    // Random part. First fill happens under a long receiver hold-off so the
    // block backs up and stalls its input while beats keep being offered.
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
    random_start = ops_issued;
    hold_ask <= hold_ask + 1;
    fill_run();
    wait_drained();
    drain_run();

    while (ops_issued - random_start < RANDOM_OPS) begin
      // a middle stretch runs flat out on both sides
      if (ops_issued - random_start >= 40 && ops_issued - random_start < 60) begin
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
      end else begin
        tx_gaps = 1'b1;
        rx_gaps <= 1'b1;
      end
      case ($urandom_range(9))
        0, 1:    fill_run();
        2, 3:    drain_run();
        default: mixed_run();
      endcase
      if ($urandom_range(9) < 3) wait_drained();
    end

    // End: everything back, let the block settle, then close the books.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("covered %0d operations and %0d spare codes, %0d result beats compared",
             ops_issued, spares_issued, chk_beats);
    $display("%0d full pushes, %0d empty answers, long hold-off and random stalls on both sides",
             chk_fulls, chk_empties);
    if (chk_fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
